// File: sv/sensor_delta_leb128_record_encoder_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor delta record encoder
// Clocked, reset-qualified property checks used by the top-level core.
// ----------------------------------------------------------------------------
`ifndef SENSOR_DELTA_LEB128_RECORD_ENCODER_CORE_MACROS_SVH
`define SENSOR_DELTA_LEB128_RECORD_ENCODER_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SDLRE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SDLRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sdlre_pkg.sv
// ----------------------------------------------------------------------------
// sdlre_pkg
// Shared types and constants of the sensor delta record encoder.
// ----------------------------------------------------------------------------
package sdlre_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned ValW     = 14;
  localparam int unsigned DeltaW   = ValW + 1;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QAw      = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  // One classified sample: either an error marker or two deltas and a check byte.
  typedef struct packed {
    logic              err;
    logic [DeltaW-1:0] delta_t;
    logic [DeltaW-1:0] delta_h;
    logic [7:0]        xor_chk;
  } rec_t;

endpackage

// File: sv/sensor_delta_leb128_record_encoder_core.sv
// ----------------------------------------------------------------------------
// sensor_delta_leb128_record_encoder_core
// Checks sensor sample CRCs and encodes temperature and humidity deltas as
// signed LEB128 records followed by a combined check byte.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: temp_word, temp_check, hum_word, hum_check;
//                        tuser: restart
//   m_axis    out        tdata: out_byte; tlast: last_byte; tuser: crc_error
//
// The front takes one sample per cycle while the queue has room.
// The back emits one record byte per cycle while the output is not stalled, so a good
// sample yields three to seven bytes and a dropped sample one byte at the output port.
// While a byte waits in the output register, the back waits with it.
// Reset clears the committed values, the queue and the output valid flag.
// ----------------------------------------------------------------------------
`include "sensor_delta_leb128_record_encoder_core_macros.svh"

module sensor_delta_leb128_record_encoder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] temp_word, [23:16] temp_check, [39:24] hum_word, [47:40] hum_check
  input  logic [sdlre_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] restart
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] out_byte
  output logic [sdlre_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  // [0] crc_error
  output logic                           m_axis_tuser
);
  import sdlre_pkg::*;

  rec_t             fr_rec, bk_rec;
  logic             fr_valid, fr_ready, bk_valid, bk_ready;
  logic [QCntW-1:0] q_count;

  sdlre_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .rec_valid_o   (fr_valid),
    .rec_ready_i   (fr_ready),
    .rec_o         (fr_rec)
  );

  sdlre_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  (fr_rec),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_data_o  (bk_rec),
    .count_o    (q_count)
  );

  sdlre_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_valid_i   (bk_valid),
    .rec_ready_o   (bk_ready),
    .rec_i         (bk_rec),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  `SDLRE_ASSERT_IMPL(a_err_form, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "error result must be a single zero byte")
  `SDLRE_ASSERT_NEXT(a_rec_cont, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "record bytes must follow without a gap")
  `SDLRE_ASSERT_IMPL(a_q_room, s_axis_tvalid && s_axis_tready, q_count < QCntW'(QDepth), "request accepted into a full queue")

endmodule

// File: sv/sdlre_front.sv
// ----------------------------------------------------------------------------
// sdlre_front
// Accepts sample requests, checks both CRC bytes and forms the two deltas
// against its own copy of the committed values.
// ----------------------------------------------------------------------------
module sdlre_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sdlre_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                          s_axis_tuser,
  output logic                          rec_valid_o,
  input  logic                          rec_ready_i,
  output sdlre_pkg::rec_t               rec_o
);
  import sdlre_pkg::*;

  localparam logic [7:0] CrcPoly = 8'h31;

  function automatic logic [7:0] crc8_word(input logic [15:0] word);
    logic [7:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 15; i >= 0; i--) begin
      fb  = crc[7] ^ word[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return crc;
  endfunction

  logic [15:0]     temp_word;
  logic [7:0]      temp_check;
  logic [15:0]     hum_word;
  logic [7:0]      hum_check;
  logic            crc_ok;
  logic            accept;
  logic [ValW-1:0] t_val, h_val, t_base, h_base;
  logic [ValW-1:0] prev_t_d, prev_t_q, prev_h_d, prev_h_q;

  assign temp_word  = s_axis_tdata[15:0];
  assign temp_check = s_axis_tdata[23:16];
  assign hum_word   = s_axis_tdata[39:24];
  assign hum_check  = s_axis_tdata[47:40];

  assign crc_ok = (crc8_word(temp_word) == temp_check) && (crc8_word(hum_word) == hum_check);

  assign t_val  = temp_word[15:2];
  assign h_val  = hum_word[15:2];
  assign t_base = s_axis_tuser ? '0 : prev_t_q;
  assign h_base = s_axis_tuser ? '0 : prev_h_q;

  assign s_axis_tready = rec_ready_i;
  assign rec_valid_o   = s_axis_tvalid;
  assign accept        = s_axis_tvalid && rec_ready_i;

  always_comb begin
    rec_o.err     = !crc_ok;
    rec_o.delta_t = {1'b0, t_val} - {1'b0, t_base};
    rec_o.delta_h = {1'b0, h_val} - {1'b0, h_base};
    rec_o.xor_chk = temp_check ^ hum_check;
  end

  always_comb begin
    prev_t_d = prev_t_q;
    prev_h_d = prev_h_q;
    if (accept && crc_ok) begin
      prev_t_d = t_val;
      prev_h_d = h_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_t_q <= '0;
      prev_h_q <= '0;
    end else begin
      prev_t_q <= prev_t_d;
      prev_h_q <= prev_h_d;
    end
  end

endmodule

// File: sv/sdlre_queue.sv
// ----------------------------------------------------------------------------
// sdlre_queue
// Short first-in first-out queue of classified samples between the front
// and the back.
// ----------------------------------------------------------------------------
module sdlre_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_valid_i,
  output logic                        wr_ready_o,
  input  sdlre_pkg::rec_t             wr_data_i,
  output logic                        rd_valid_o,
  input  logic                        rd_ready_i,
  output sdlre_pkg::rec_t             rd_data_o,
  output logic [sdlre_pkg::QCntW-1:0] count_o
);
  import sdlre_pkg::*;

  rec_t             mem_q [QDepth];
  logic [QAw-1:0]   wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [QCntW-1:0] cnt_d, cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != QCntW'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign count_o    = cnt_q;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// File: sv/sdlre_back.sv
// ----------------------------------------------------------------------------
// sdlre_back
// Turns one classified sample into its record bytes, one signed LEB128 byte
// per cycle while the output is not stalled, and drives the registered output stream.
// ----------------------------------------------------------------------------
module sdlre_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rec_valid_i,
  output logic                           rec_ready_o,
  input  sdlre_pkg::rec_t                rec_i,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sdlre_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser
);
  import sdlre_pkg::*;

  localparam logic [1:0] SelTemp = 2'd0;
  localparam logic [1:0] SelHum  = 2'd1;
  localparam logic [1:0] SelChk  = 2'd2;

  logic              busy_d, busy_q;
  logic [1:0]        sel_d, sel_q;
  logic [DeltaW-1:0] n_d, n_q, dh_d, dh_q;
  logic [7:0]        xb_d, xb_q;
  logic              err_d, err_q;
  logic              out_free, emit, pop, fits;
  logic [7:0]        byte_val;
  logic              byte_last;
  logic              ov_d, ov_q;
  logic [7:0]        od_d, od_q;
  logic              ol_d, ol_q, ou_d, ou_q;

  assign out_free = !ov_q || m_axis_tready;
  assign emit     = busy_q && out_free;
  assign fits     = (&n_q[DeltaW-1:6]) || !(|n_q[DeltaW-1:6]);

  always_comb begin
    byte_val  = 8'h00;
    byte_last = 1'b0;
    if (err_q) begin
      byte_last = 1'b1;
    end else begin
      case (sel_q)
        SelTemp, SelHum: begin
          byte_val = {!fits, n_q[6:0]};
        end
        SelChk: begin
          byte_val  = xb_q;
          byte_last = 1'b1;
        end
        default: begin
          byte_val  = xb_q;
          byte_last = 1'b1;
        end
      endcase
    end
  end

  assign pop         = rec_valid_i && (!busy_q || (emit && byte_last));
  assign rec_ready_o = pop;

  always_comb begin
    busy_d = busy_q;
    sel_d  = sel_q;
    n_d    = n_q;
    dh_d   = dh_q;
    xb_d   = xb_q;
    err_d  = err_q;
    if (emit) begin
      if (byte_last) begin
        busy_d = 1'b0;
      end else if (fits) begin
        if (sel_q == SelTemp) begin
          n_d   = dh_q;
          sel_d = SelHum;
        end else begin
          sel_d = SelChk;
        end
      end else begin
        n_d = DeltaW'($signed(n_q) >>> 7);
      end
    end
    if (pop) begin
      busy_d = 1'b1;
      sel_d  = SelTemp;
      n_d    = rec_i.delta_t;
      dh_d   = rec_i.delta_h;
      xb_d   = rec_i.xor_chk;
      err_d  = rec_i.err;
    end
  end

  always_comb begin
    ov_d = ov_q;
    od_d = od_q;
    ol_d = ol_q;
    ou_d = ou_q;
    if (m_axis_tready) begin
      ov_d = 1'b0;
    end
    if (emit) begin
      ov_d = 1'b1;
      od_d = byte_val;
      ol_d = byte_last;
      ou_d = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sel_q  <= SelTemp;
      err_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      sel_q  <= sel_d;
      err_q  <= err_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    dh_q <= dh_d;
    xb_q <= xb_d;
    od_q <= od_d;
    ol_q <= ol_d;
    ou_q <= ou_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = ou_q;

endmodule
